// ===== rtl/core/bpbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpbs_pkg
// Shared constants, codes and stream field layout of the bone palette
// batch splitter.
// ----------------------------------------------------------------------------
package bpbs_pkg;

	// table sizes
	localparam int COMBO_DEPTH      = 4096;
	localparam int VERTEX_DEPTH     = 4096;
	localparam int PALETTE_DEPTH    = 64;
	localparam int IDS_PER_TRIANGLE = 12;

	// derived widths
	localparam int COMBO_AW  = $clog2(COMBO_DEPTH);
	localparam int VERTEX_AW = $clog2(VERTEX_DEPTH);
	localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
	localparam int PCNT_W    = $clog2(PALETTE_DEPTH + 1);
	localparam int LANE_W    = $clog2(IDS_PER_TRIANGLE);
	localparam int IDCNT_W   = $clog2(IDS_PER_TRIANGLE + 1);
	localparam int CMP_W     = (PCNT_W + 1 > 8) ? PCNT_W + 1 : 8;
	localparam int BONE_W    = 16;

	// input item kinds (tuser)
	localparam logic [1:0] ACT_LOAD_COMBO = 2'd0;
	localparam logic [1:0] ACT_LOAD_INFL  = 2'd1;
	localparam logic [1:0] ACT_TRIANGLE   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_BONES    = 2'd0;
	localparam logic [1:0] REG_COMBO_BASE   = 2'd1;
	localparam logic [1:0] REG_COMBO_COUNT  = 2'd2;
	localparam logic [1:0] REG_VERTEX_COUNT = 2'd3;

	// input tdata layout
	localparam int IN_LI_LSB   = 0;
	localparam int IN_CV_LSB   = 12;
	localparam int IN_INF_LSB  = 28;
	localparam int IN_VA_LSB   = 60;
	localparam int IN_VB_LSB   = 76;
	localparam int IN_VC_LSB   = 92;
	localparam int IN_DATA_W   = 112;

	// output tdata layout
	localparam int OUT_START_LSB = 0;
	localparam int OUT_END_LSB   = 16;
	localparam int OUT_SIZE_LSB  = 32;
	localparam int OUT_ERR_BIT   = 39;
	localparam int OUT_DATA_W    = 40;

	// one reported section
	typedef struct packed {
		logic        last;
		logic        err;
		logic [6:0]  size;
		logic [15:0] sec_end;
		logic [15:0] sec_start;
	} result_t;

endpackage

// ===== rtl/core/bone_palette_batch_splitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bone_palette_batch_splitter_unit
// Greedy split of a triangle stream into draw sections whose bone palettes
// stay within max_bones; tables and palette live in synchronous memories.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: action; tdata: load_index, combo_value,
//           |           | influences, vertex_a/b/c; tlast: last_triangle
//  m_axis   | out       | tdata: section_start, section_end, palette_size,
//           |           | error; tlast: last
//  cfg      | in        | cfg_we, cfg_index, cfg_wdata
//
// A load item is written as it is accepted. A triangle makes three influence
// reads and twelve combination reads on single read ports, then a palette
// scan of one entry a cycle and twelve append slots. A triangle with a bad
// vertex id ends the submesh with an error report. Results wait in a
// two-entry output queue; the block stalls only when a result has no room.
// Reset clears counters and queue; max_bones resets to 64.
// ----------------------------------------------------------------------------
module bone_palette_batch_splitter_unit (
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: load_index[11:0], combo_value[27:12], influences[59:28],
	// vertex_a[75:60], vertex_b[91:76], vertex_c[107:92], zero pad
	input  logic [111:0] s_axis_tdata,
	// tuser: action[1:0]
	input  logic [1:0]   s_axis_tuser,
	input  logic         s_axis_tlast,
	// result items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: section_start[15:0], section_end[31:16], palette_size[38:32],
	// error[39]
	output logic [39:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	// configuration writes
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);

	localparam int CAW    = bpbs_pkg::COMBO_AW;
	localparam int VAW    = bpbs_pkg::VERTEX_AW;
	localparam int PAW    = bpbs_pkg::PAL_AW;
	localparam int PCW    = bpbs_pkg::PCNT_W;
	localparam int LW     = bpbs_pkg::LANE_W;
	localparam int ICW    = bpbs_pkg::IDCNT_W;
	localparam int CW     = bpbs_pkg::CMP_W;
	localparam int BW     = bpbs_pkg::BONE_W;
	localparam int NIDS   = bpbs_pkg::IDS_PER_TRIANGLE;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_INFL   = 3'd2;
	localparam logic [2:0] ST_COMBO  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_APPEND = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	// configuration registers
	logic [6:0]  max_bones_q;
	logic [15:0] combo_base_q;
	logic [12:0] combo_count_q;
	logic [12:0] vertex_count_q;

	// control state
	logic [2:0]     state_q;
	logic [LW-1:0]  cnt_q;
	logic [PCW-1:0] scnt_q;
	logic [PCW-1:0] pcount_q;
	logic [15:0]    first_q;
	logic [15:0]    tri_q;
	logic           split_q;
	logic [ICW-1:0] nid_q;
	logic [NIDS-1:0] hit_q;
	logic           infl_vld_s1;
	logic           combo_vld_s1;
	logic           pal_vld_s1;

	// per-triangle payload
	logic [15:0]    vtx_q [3];
	logic           last_q;
	logic [31:0]    word_q [3];
	logic [BW-1:0]  ids_q [NIDS];
	logic [1:0]     infl_sel_s1;
	logic           combo_ok_s1;

	// memories
	logic [15:0]    combo_mem [bpbs_pkg::COMBO_DEPTH];
	logic [31:0]    infl_mem  [bpbs_pkg::VERTEX_DEPTH];
	logic [BW-1:0]  pal_mem   [bpbs_pkg::PALETTE_DEPTH];
	logic [15:0]    combo_rdata_s1;
	logic [31:0]    infl_rdata_s1;
	logic [BW-1:0]  pal_rdata_s1;

	// output queue
	bpbs_pkg::result_t fifo_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        fcnt_q;

	// input fields
	logic [11:0] in_li;
	logic [15:0] in_cv;
	logic [31:0] in_inf;
	logic        in_acc;

	assign in_li  = s_axis_tdata[bpbs_pkg::IN_LI_LSB +: 12];
	assign in_cv  = s_axis_tdata[bpbs_pkg::IN_CV_LSB +: 16];
	assign in_inf = s_axis_tdata[bpbs_pkg::IN_INF_LSB +: 32];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// table loads
	logic           combo_we;
	logic           infl_we;

	assign combo_we = in_acc && (s_axis_tuser == bpbs_pkg::ACT_LOAD_COMBO)
		&& (17'(in_li) < 17'(bpbs_pkg::COMBO_DEPTH));
	assign infl_we  = in_acc && (s_axis_tuser == bpbs_pkg::ACT_LOAD_INFL)
		&& (17'(in_li) < 17'(bpbs_pkg::VERTEX_DEPTH));

	// combination index of the current influence byte
	logic [7:0]     cur_byte;
	logic [16:0]    cidx;
	logic           cidx_ok;

	always_comb begin
		cur_byte = word_q[cnt_q[3:2]][{cnt_q[1:0], 3'b000} +: 8];
		cidx     = {1'b0, combo_base_q} + 17'(cur_byte);
		cidx_ok  = (cidx < 17'(combo_count_q)) && (cidx < 17'(bpbs_pkg::COMBO_DEPTH));
	end

	// vertex range check
	logic vtx_bad;

	always_comb begin
		vtx_bad = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if ((vtx_q[k] >= {3'b000, vertex_count_q})
				|| (17'(vtx_q[k]) >= 17'(bpbs_pkg::VERTEX_DEPTH))) begin
				vtx_bad = 1'b1;
			end
		end
	end

	// append slot
	logic           pal_we;

	assign pal_we = (state_q == ST_APPEND) && (ICW'(cnt_q) < nid_q)
		&& (split_q || !hit_q[cnt_q]) && (pcount_q < PCW'(bpbs_pkg::PALETTE_DEPTH));

	// memory ports
	always_ff @(posedge clk) begin
		if (combo_we) begin
			combo_mem[CAW'(in_li)] <= in_cv;
		end
		combo_rdata_s1 <= combo_mem[cidx[CAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (infl_we) begin
			infl_mem[VAW'(in_li)] <= in_inf;
		end
		infl_rdata_s1 <= infl_mem[VAW'(vtx_q[cnt_q[1:0]])];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pcount_q[PAW-1:0]] <= ids_q[cnt_q];
		end
		pal_rdata_s1 <= pal_mem[scnt_q[PAW-1:0]];
	end

	// resolved id and its duplicate check
	logic [BW-1:0] gid;
	logic          gid_seen;

	always_comb begin
		gid      = combo_ok_s1 ? combo_rdata_s1 : '0;
		gid_seen = 1'b0;
		for (int e = 0; e < NIDS; e++) begin
			if ((ICW'(e) < nid_q) && (ids_q[e] == gid)) begin
				gid_seen = 1'b1;
			end
		end
	end

	// split decision
	logic [ICW-1:0] known;
	logic [ICW-1:0] fresh;
	logic [CW-1:0]  lim;
	logic [CW-1:0]  mb;
	logic           do_split;

	always_comb begin
		known = '0;
		for (int e = 0; e < NIDS; e++) begin
			if (hit_q[e] && (ICW'(e) < nid_q)) begin
				known = known + ICW'(1);
			end
		end
		fresh    = nid_q - known;
		mb       = CW'(max_bones_q);
		lim      = (mb > CW'(bpbs_pkg::PALETTE_DEPTH)) ? CW'(bpbs_pkg::PALETTE_DEPTH) : mb;
		do_split = ((CW'(pcount_q) + CW'(fresh)) > lim) && (tri_q != first_q);
	end

	// result push
	logic              fifo_space;
	logic              push_en;
	bpbs_pkg::result_t push_res;
	logic [15:0]       tri_next;

	assign fifo_space = (fcnt_q != 2'd2);
	assign tri_next   = tri_q + 16'd1;

	always_comb begin
		push_en  = 1'b0;
		push_res = '0;
		case (state_q)
			ST_CHECK: begin
				push_en            = vtx_bad && fifo_space;
				push_res.sec_start = first_q;
				push_res.sec_end   = tri_q;
				push_res.err       = 1'b1;
				push_res.last      = 1'b1;
			end
			ST_DECIDE: begin
				push_en            = do_split && fifo_space;
				push_res.sec_start = first_q;
				push_res.sec_end   = tri_q;
				push_res.size      = 7'(pcount_q);
			end
			ST_FINISH: begin
				push_en            = last_q && fifo_space;
				push_res.sec_start = first_q;
				push_res.sec_end   = tri_next;
				push_res.size      = 7'(pcount_q);
				push_res.last      = 1'b1;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bones_q    <= 7'd64;
			combo_base_q   <= '0;
			combo_count_q  <= '0;
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpbs_pkg::REG_MAX_BONES:    max_bones_q    <= cfg_wdata[6:0];
				bpbs_pkg::REG_COMBO_BASE:   combo_base_q   <= cfg_wdata;
				bpbs_pkg::REG_COMBO_COUNT:  combo_count_q  <= cfg_wdata[12:0];
				bpbs_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			scnt_q       <= '0;
			pcount_q     <= '0;
			first_q      <= '0;
			tri_q        <= '0;
			split_q      <= 1'b0;
			nid_q        <= '0;
			hit_q        <= '0;
			infl_vld_s1  <= 1'b0;
			combo_vld_s1 <= 1'b0;
			pal_vld_s1   <= 1'b0;
		end else begin
			infl_vld_s1  <= (state_q == ST_INFL);
			combo_vld_s1 <= (state_q == ST_COMBO);
			pal_vld_s1   <= (state_q == ST_SCAN) && (scnt_q < pcount_q);

			// collect distinct ids one a cycle
			if (combo_vld_s1 && !gid_seen && (nid_q < ICW'(NIDS))) begin
				nid_q <= nid_q + ICW'(1);
			end

			// mark ids already in the palette
			if (pal_vld_s1) begin
				for (int e = 0; e < NIDS; e++) begin
					if (pal_rdata_s1 == ids_q[e]) begin
						hit_q[e] <= 1'b1;
					end
				end
			end

			if (pal_we) begin
				pcount_q <= pcount_q + PCW'(1);
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == bpbs_pkg::ACT_TRIANGLE)) begin
						nid_q   <= '0;
						hit_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (vtx_bad) begin
						if (push_en) begin
							pcount_q <= '0;
							first_q  <= '0;
							tri_q    <= '0;
							state_q  <= ST_IDLE;
						end
					end else begin
						cnt_q   <= '0;
						state_q <= ST_INFL;
					end
				end
				ST_INFL: begin
					if (cnt_q == LW'(2)) begin
						cnt_q   <= '0;
						state_q <= ST_COMBO;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				ST_COMBO: begin
					if (cnt_q == LW'(NIDS - 1)) begin
						scnt_q  <= '0;
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				ST_SCAN: begin
					if (scnt_q == pcount_q) begin
						state_q <= ST_DECIDE;
					end else begin
						scnt_q <= scnt_q + PCW'(1);
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (do_split) begin
						if (push_en) begin
							pcount_q <= '0;
							first_q  <= tri_q;
							split_q  <= 1'b1;
							state_q  <= ST_APPEND;
						end
					end else begin
						split_q <= 1'b0;
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (cnt_q == LW'(NIDS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				ST_FINISH: begin
					if (last_q) begin
						if (push_en) begin
							pcount_q <= '0;
							first_q  <= '0;
							tri_q    <= '0;
							state_q  <= ST_IDLE;
						end
					end else begin
						tri_q   <= tri_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// triangle payload and read pipeline data
	always_ff @(posedge clk) begin
		if (in_acc && (s_axis_tuser == bpbs_pkg::ACT_TRIANGLE)) begin
			vtx_q[0] <= s_axis_tdata[bpbs_pkg::IN_VA_LSB +: 16];
			vtx_q[1] <= s_axis_tdata[bpbs_pkg::IN_VB_LSB +: 16];
			vtx_q[2] <= s_axis_tdata[bpbs_pkg::IN_VC_LSB +: 16];
			last_q   <= s_axis_tlast;
		end
		infl_sel_s1 <= cnt_q[1:0];
		combo_ok_s1 <= cidx_ok;
		if (infl_vld_s1) begin
			word_q[infl_sel_s1] <= infl_rdata_s1;
		end
		if (combo_vld_s1 && !gid_seen && (nid_q < ICW'(NIDS))) begin
			ids_q[nid_q[LW-1:0]] <= gid;
		end
	end

	// output queue control
	logic pop_en;

	assign pop_en = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (push_en) begin
				wptr_q <= !wptr_q;
			end
			if (pop_en) begin
				rptr_q <= !rptr_q;
			end
			case ({push_en, pop_en})
				2'b10:   fcnt_q <= fcnt_q + 2'd1;
				2'b01:   fcnt_q <= fcnt_q - 2'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_q[wptr_q] <= push_res;
		end
	end

	// result port
	bpbs_pkg::result_t head;

	assign head          = fifo_q[rptr_q];
	assign m_axis_tvalid = (fcnt_q != 2'd0);
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {head.err, head.size, head.sec_end, head.sec_start};

endmodule

// ===== rtl/core/bpbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpbs_checker
// Port-level checks on the result stream of the bone palette batch splitter.
// ----------------------------------------------------------------------------
module bpbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	// an error report always closes the submesh
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[bpbs_pkg::OUT_ERR_BIT] |-> m_axis_tlast)
		else $error("error item without last");

	// an error report carries no palette
	a_err_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[bpbs_pkg::OUT_ERR_BIT]
		|-> m_axis_tdata[bpbs_pkg::OUT_SIZE_LSB +: 7] == 7'd0)
		else $error("error item with nonzero palette size");

	// a split report holds at least one bone and never more than the palette
	a_split_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast
		|-> (m_axis_tdata[bpbs_pkg::OUT_SIZE_LSB +: 7] != 7'd0)
		&& (8'(m_axis_tdata[bpbs_pkg::OUT_SIZE_LSB +: 7]) <= 8'(bpbs_pkg::PALETTE_DEPTH)))
		else $error("split item with bad palette size");

endmodule

bind bone_palette_batch_splitter_unit bpbs_checker u_bpbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
